/* src/tpsc_pkg.sv */
// ----------------------------------------------------------------------------
// tpsc_pkg
// Types, codes and constants shared by the two-point scale calibration core.
// ----------------------------------------------------------------------------
package tpsc_pkg;

  localparam int SER_W  = 32;   // width of the bit-serial compare pass
  localparam int LVL_W  = 24;   // load-cell reading width
  localparam int WG_W   = 12;   // known weight width
  localparam int DM_W   = 22;   // reading difference kept for the divider
  localparam int FRAC_W = 16;   // fraction bits of the scale factor
  localparam int Q_W    = 26;   // scale factor width
  localparam int DIV_W  = DM_W + FRAC_W;

  // phase codes
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_TRIG       = 4'd1;
  localparam logic [3:0] PH_STARTED    = 4'd2;
  localparam logic [3:0] PH_WAIT_EMPTY = 4'd3;
  localparam logic [3:0] PH_MEAS_EMPTY = 4'd4;
  localparam logic [3:0] PH_WAIT_FULL  = 4'd5;
  localparam logic [3:0] PH_MEAS_FULL  = 4'd6;
  localparam logic [3:0] PH_COMPLETE   = 4'd7;
  localparam logic [3:0] PH_ERROR      = 4'd8;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_TIMEOUT = 2'd1;
  localparam logic [1:0] ERR_FACTOR  = 2'd2;
  localparam logic [1:0] ERR_SAVE    = 2'd3;

  // event kinds
  localparam logic [1:0] FN_UPDATE = 2'd0;
  localparam logic [1:0] FN_START  = 2'd1;
  localparam logic [1:0] FN_CANCEL = 2'd2;

  // gestures
  localparam logic [1:0] GS_UPRIGHT  = 2'd1;
  localparam logic [1:0] GS_INVERTED = 2'd2;

  // register indexes
  localparam logic [2:0] CFG_STARTED_DISPLAY = 3'd0;
  localparam logic [2:0] CFG_EMPTY_TIMEOUT   = 3'd1;
  localparam logic [2:0] CFG_FULL_TIMEOUT    = 3'd2;
  localparam logic [2:0] CFG_NET_GRAMS       = 3'd3;
  localparam logic [2:0] CFG_FILL_THRESHOLD  = 3'd4;
  localparam logic [2:0] CFG_STABILITY_BAND  = 3'd5;
  localparam logic [2:0] CFG_STABLE_HOLD     = 3'd6;

  // register reset values
  localparam logic [15:0] RST_STARTED_DISPLAY = 16'd3000;
  localparam logic [31:0] RST_EMPTY_TIMEOUT   = 32'd60000;
  localparam logic [31:0] RST_FULL_TIMEOUT    = 32'd120000;
  localparam logic [11:0] RST_NET_GRAMS       = 12'd830;
  localparam logic [23:0] RST_FILL_THRESHOLD  = 24'd300000;
  localparam logic [23:0] RST_STABILITY_BAND  = 24'd5000;
  localparam logic [15:0] RST_STABLE_HOLD     = 16'd5000;

  typedef struct packed {
    logic [1:0]              func;
    logic [31:0]             now_ms;
    logic [1:0]              gesture;
    logic signed [LVL_W-1:0] live_level;
    logic                    meas_valid;
    logic                    meas_stable;
    logic signed [LVL_W-1:0] meas_raw;
    logic                    save_ok;
  } req_t;

  typedef struct packed {
    logic [3:0]              phase;
    logic                    cal_mode;
    logic                    success;
    logic [1:0]              error_code;
    logic signed [LVL_W-1:0] empty_level;
    logic signed [LVL_W-1:0] full_level;
    logic [Q_W-1:0]          scale_q16;
    logic                    save_request;
  } rsp_t;

  // operands of one serial compare pass
  typedef struct packed {
    logic [SER_W-1:0] now_ms;
    logic [SER_W-1:0] t_start;
    logic [SER_W-1:0] t_limit;
    logic [SER_W-1:0] h_start;
    logic [SER_W-1:0] h_limit;
    logic [SER_W-1:0] load;
    logic [SER_W-1:0] empty;
    logic [SER_W-1:0] last;
    logic [SER_W-1:0] thr;
    logic [SER_W-1:0] band;
    logic [SER_W-1:0] mraw;
    logic [SER_W-1:0] lim;
  } ser_ops_t;

  // outcome of one serial compare pass
  typedef struct packed {
    logic            t_ge;
    logic            h_ge;
    logic            fill_hit;
    logic            band_hit;
    logic            fac_ok;
    logic [DM_W-1:0] dm;
  } ser_res_t;

endpackage

/* src/tpsc_serial.sv */
// ----------------------------------------------------------------------------
// tpsc_serial
// Bit-serial compare unit: all timer, band and factor tests, LSB first.
// ----------------------------------------------------------------------------
module tpsc_serial (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  tpsc_pkg::ser_ops_t ops,
  output logic               done,
  output tpsc_pkg::ser_res_t res
);

  localparam int CntW = $clog2(tpsc_pkg::SER_W);

  function automatic logic [1:0] fa(input logic a, input logic b, input logic ci);
    fa = {(a & b) | (a & ci) | (b & ci), a ^ b ^ ci};
  endfunction

  tpsc_pkg::ser_ops_t         sr;
  logic [CntW-1:0]            cnt;
  logic                       run;
  logic                       c_t1, c_t2, c_h1, c_h2;
  logic                       c_f1, c_f2, c_f3, f2s, f3s;
  logic                       c_b1, c_b2, c_b3, b2s, b3s, b3nz;
  logic                       c_m1, c_m2, m1s, m1nz, m2s;
  logic [tpsc_pkg::DM_W-1:0]  dm_sr;

  logic [1:0] t1, t2, h1, h2, f1, f2, f3, b1, b2, b3, m1, m2;

  always_comb begin
    t1 = fa(sr.now_ms[0], ~sr.t_start[0], c_t1);
    t2 = fa(t1[0], ~sr.t_limit[0], c_t2);
    h1 = fa(sr.now_ms[0], ~sr.h_start[0], c_h1);
    h2 = fa(h1[0], ~sr.h_limit[0], c_h2);
    f1 = fa(sr.load[0], ~sr.empty[0], c_f1);
    f2 = fa(sr.thr[0], ~f1[0], c_f2);
    f3 = fa(sr.thr[0], f1[0], c_f3);
    b1 = fa(sr.load[0], ~sr.last[0], c_b1);
    b2 = fa(b1[0], ~sr.band[0], c_b2);
    b3 = fa(b1[0], sr.band[0], c_b3);
    m1 = fa(sr.mraw[0], ~sr.empty[0], c_m1);
    m2 = fa(sr.lim[0], ~m1[0], c_m2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(tpsc_pkg::SER_W - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sr   <= ops;
      c_t1 <= 1'b1; c_t2 <= 1'b1;
      c_h1 <= 1'b1; c_h2 <= 1'b1;
      c_f1 <= 1'b1; c_f2 <= 1'b1; c_f3 <= 1'b0;
      c_b1 <= 1'b1; c_b2 <= 1'b1; c_b3 <= 1'b0;
      c_m1 <= 1'b1; c_m2 <= 1'b1;
      b3nz <= 1'b0;
      m1nz <= 1'b0;
    end else if (run) begin
      sr.now_ms  <= sr.now_ms >> 1;
      sr.t_start <= sr.t_start >> 1;
      sr.t_limit <= sr.t_limit >> 1;
      sr.h_start <= sr.h_start >> 1;
      sr.h_limit <= sr.h_limit >> 1;
      sr.load    <= sr.load >> 1;
      sr.empty   <= sr.empty >> 1;
      sr.last    <= sr.last >> 1;
      sr.thr     <= sr.thr >> 1;
      sr.band    <= sr.band >> 1;
      sr.mraw    <= sr.mraw >> 1;
      sr.lim     <= sr.lim >> 1;
      c_t1 <= t1[1]; c_t2 <= t2[1];
      c_h1 <= h1[1]; c_h2 <= h2[1];
      c_f1 <= f1[1]; c_f2 <= f2[1]; c_f3 <= f3[1];
      f2s  <= f2[0]; f3s  <= f3[0];
      c_b1 <= b1[1]; c_b2 <= b2[1]; c_b3 <= b3[1];
      b2s  <= b2[0]; b3s  <= b3[0];
      b3nz <= b3nz | b3[0];
      c_m1 <= m1[1]; c_m2 <= m2[1];
      m1s  <= m1[0]; m2s  <= m2[0];
      m1nz <= m1nz | m1[0];
      if (cnt < CntW'(tpsc_pkg::DM_W)) begin
        dm_sr <= {m1[0], dm_sr[tpsc_pkg::DM_W-1:1]};
      end
    end
  end

  // final carries give unsigned >=, top sum bits give signs
  always_comb begin
    res.t_ge     = c_t2;
    res.h_ge     = c_h2;
    res.fill_hit = f2s | f3s;
    res.band_hit = b2s & ~b3s & b3nz;
    res.fac_ok   = ~m1s & m1nz & ~m2s;
    res.dm       = dm_sr;
  end

endmodule

/* src/tpsc_div.sv */
// ----------------------------------------------------------------------------
// tpsc_div
// Bit-serial restoring divider for the Q10.16 scale factor.
// ----------------------------------------------------------------------------
module tpsc_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tpsc_pkg::DM_W-1:0]  dm,
  input  logic [tpsc_pkg::WG_W-1:0]  grams,
  output logic                       done,
  output logic [tpsc_pkg::Q_W-1:0]   quo
);

  localparam int DivW = tpsc_pkg::DIV_W;
  localparam int WgW  = tpsc_pkg::WG_W;
  localparam int CntW = $clog2(DivW);

  logic [DivW-1:0] dvd;
  logic [WgW-1:0]  rem;
  logic [CntW-1:0] cnt;
  logic            run;
  logic [WgW:0]    r2;
  logic [WgW:0]    rdiff;
  logic            ge;

  always_comb begin
    r2    = {rem, dvd[DivW-1]};
    rdiff = r2 - {1'b0, grams};
    ge    = r2 >= {1'b0, grams};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == CntW'(DivW - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= {dm, {tpsc_pkg::FRAC_W{1'b0}}};
      rem <= '0;
    end else if (run) begin
      dvd <= dvd << 1;
      rem <= ge ? rdiff[WgW-1:0] : r2[WgW-1:0];
      quo <= {quo[tpsc_pkg::Q_W-2:0], ge};
    end
  end

endmodule

/* src/two_point_scale_calibration_fsm_core.sv */
// ----------------------------------------------------------------------------
// two_point_scale_calibration_fsm_core
// Two-point load-cell calibration sequencer with bit-serial arithmetic.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and answered by exactly one response
// beat. Every beat passes through the serial unit before the next ready: the
// timer, fill, stability-band and factor-range tests all run LSB first
// through one 32-bit serial compare pass. A full measurement that yields a
// valid factor and a good save adds the 38-step restoring divider. A finished
// response waits in the output register, and the next request is accepted
// while it waits.
module two_point_scale_calibration_fsm_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  tpsc_pkg::req_t    req_data,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output tpsc_pkg::rsp_t    rsp_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_addr,
  input  logic [31:0]       cfg_wdata
);

  localparam int SerW = tpsc_pkg::SER_W;
  localparam int LvlW = tpsc_pkg::LVL_W;

  typedef enum logic [3:0] {
    CT_IDLE = 4'b0001,
    CT_SER  = 4'b0010,
    CT_DIV  = 4'b0100,
    CT_DONE = 4'b1000
  } ctrl_t;

  ctrl_t ctrl;

  // configuration
  logic [15:0] started_display_ms;
  logic [31:0] empty_timeout_ms;
  logic [31:0] full_timeout_ms;
  logic [11:0] net_grams;
  logic [23:0] fill_threshold;
  logic [23:0] stability_band;
  logic [15:0] stable_hold_ms;

  // sequencer state
  logic [3:0]              phase_reg, phase_next;
  logic [31:0]             phase_start_time, phase_start_time_next;
  logic [31:0]             empty_wait_start, empty_wait_start_next;
  logic [31:0]             full_wait_start, full_wait_start_next;
  logic [31:0]             stable_start_time, stable_start_time_next;
  logic [LvlW-1:0]         last_level, last_level_next;
  logic                    is_stable, is_stable_next;
  logic [LvlW-1:0]         empty_reg, empty_reg_next;
  logic [LvlW-1:0]         full_reg, full_reg_next;
  logic [tpsc_pkg::Q_W-1:0] scale_reg, scale_reg_next;
  logic                    mode_flag, mode_flag_next;
  logic                    success_flag, success_flag_next;
  logic [1:0]              error_reg, error_reg_next;
  logic                    save_req;

  tpsc_pkg::req_t     req_q;
  tpsc_pkg::ser_ops_t ops;
  tpsc_pkg::ser_res_t sres;
  logic               ser_done;
  logic               div_start;
  logic               div_done;
  logic [tpsc_pkg::Q_W-1:0] quo;
  logic               accept;
  logic               commit;
  logic               need_div;
  logic               abortable;
  logic               clear_run;
  logic [SerW-1:0]    lim;

  assign req_ready = (ctrl == CT_IDLE);
  assign accept    = req_valid && req_ready;
  assign commit    = (ctrl == CT_DONE) && (!rsp_valid || rsp_ready);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      started_display_ms <= tpsc_pkg::RST_STARTED_DISPLAY;
      empty_timeout_ms   <= tpsc_pkg::RST_EMPTY_TIMEOUT;
      full_timeout_ms    <= tpsc_pkg::RST_FULL_TIMEOUT;
      net_grams          <= tpsc_pkg::RST_NET_GRAMS;
      fill_threshold     <= tpsc_pkg::RST_FILL_THRESHOLD;
      stability_band     <= tpsc_pkg::RST_STABILITY_BAND;
      stable_hold_ms     <= tpsc_pkg::RST_STABLE_HOLD;
    end else if (cfg_we) begin
      case (cfg_addr)
        tpsc_pkg::CFG_STARTED_DISPLAY: started_display_ms <= cfg_wdata[15:0];
        tpsc_pkg::CFG_EMPTY_TIMEOUT:   empty_timeout_ms   <= cfg_wdata;
        tpsc_pkg::CFG_FULL_TIMEOUT:    full_timeout_ms    <= cfg_wdata;
        tpsc_pkg::CFG_NET_GRAMS:       net_grams          <= cfg_wdata[11:0];
        tpsc_pkg::CFG_FILL_THRESHOLD:  fill_threshold     <= cfg_wdata[23:0];
        tpsc_pkg::CFG_STABILITY_BAND:  stability_band     <= cfg_wdata[23:0];
        tpsc_pkg::CFG_STABLE_HOLD:     stable_hold_ms     <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // net_grams * 1000 as shifts
  assign lim = (SerW'(net_grams) << 10) - (SerW'(net_grams) << 4)
             - (SerW'(net_grams) << 3);

  // operands of the serial pass, taken from the incoming beat and the sequencer state
  always_comb begin
    ops.now_ms  = req_data.now_ms;
    ops.h_start = stable_start_time;
    ops.h_limit = SerW'(stable_hold_ms);
    ops.load    = {{(SerW-LvlW){req_data.live_level[LvlW-1]}}, req_data.live_level};
    ops.empty   = {{(SerW-LvlW){empty_reg[LvlW-1]}}, empty_reg};
    ops.last    = {{(SerW-LvlW){last_level[LvlW-1]}}, last_level};
    ops.thr     = SerW'(fill_threshold);
    ops.band    = SerW'(stability_band);
    ops.mraw    = {{(SerW-LvlW){req_data.meas_raw[LvlW-1]}}, req_data.meas_raw};
    ops.lim     = lim;
    case (phase_reg)
      tpsc_pkg::PH_STARTED: begin
        ops.t_start = phase_start_time;
        ops.t_limit = SerW'(started_display_ms);
      end
      tpsc_pkg::PH_WAIT_EMPTY: begin
        ops.t_start = empty_wait_start;
        ops.t_limit = empty_timeout_ms;
      end
      default: begin
        ops.t_start = full_wait_start;
        ops.t_limit = full_timeout_ms;
      end
    endcase
  end

  tpsc_serial u_ser (
    .clk   (clk),
    .rst   (rst),
    .start (accept),
    .ops   (ops),
    .done  (ser_done),
    .res   (sres)
  );

  tpsc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .dm    (sres.dm),
    .grams (net_grams),
    .done  (div_done),
    .quo   (quo)
  );

  assign abortable = phase_reg inside {[tpsc_pkg::PH_STARTED:tpsc_pkg::PH_MEAS_FULL]};

  assign need_div = (req_q.func == tpsc_pkg::FN_UPDATE)
                 && (phase_reg == tpsc_pkg::PH_MEAS_FULL)
                 && (req_q.gesture != tpsc_pkg::GS_INVERTED)
                 && req_q.meas_valid && req_q.meas_stable && req_q.save_ok
                 && sres.fac_ok && (net_grams != '0);

  assign div_start = (ctrl == CT_SER) && ser_done && need_div;

  // sequencer next state
  always_comb begin
    phase_next             = phase_reg;
    phase_start_time_next  = phase_start_time;
    empty_wait_start_next  = empty_wait_start;
    full_wait_start_next   = full_wait_start;
    stable_start_time_next = stable_start_time;
    last_level_next        = last_level;
    is_stable_next         = is_stable;
    empty_reg_next         = empty_reg;
    full_reg_next          = full_reg;
    scale_reg_next         = scale_reg;
    mode_flag_next         = mode_flag;
    success_flag_next      = success_flag;
    error_reg_next         = error_reg;
    save_req               = 1'b0;
    clear_run              = 1'b0;
    case (req_q.func)
      tpsc_pkg::FN_START: begin
        mode_flag_next        = 1'b1;
        phase_next            = tpsc_pkg::PH_TRIG;
        phase_start_time_next = req_q.now_ms;
        success_flag_next     = 1'b0;
        error_reg_next        = tpsc_pkg::ERR_NONE;
        clear_run             = 1'b1;
      end
      tpsc_pkg::FN_CANCEL: begin
        mode_flag_next = 1'b0;
        phase_next     = tpsc_pkg::PH_IDLE;
        clear_run      = 1'b1;
      end
      tpsc_pkg::FN_UPDATE: begin
        if (abortable && req_q.gesture == tpsc_pkg::GS_INVERTED) begin
          mode_flag_next = 1'b0;
          phase_next     = tpsc_pkg::PH_IDLE;
          clear_run      = 1'b1;
        end else begin
          case (phase_reg)
            tpsc_pkg::PH_TRIG: begin
              phase_next            = tpsc_pkg::PH_STARTED;
              phase_start_time_next = req_q.now_ms;
            end
            tpsc_pkg::PH_STARTED: begin
              if (sres.t_ge) begin
                phase_next            = tpsc_pkg::PH_WAIT_EMPTY;
                empty_wait_start_next = req_q.now_ms;
              end
            end
            tpsc_pkg::PH_WAIT_EMPTY: begin
              if (sres.t_ge) begin
                phase_next     = tpsc_pkg::PH_ERROR;
                error_reg_next = tpsc_pkg::ERR_TIMEOUT;
                mode_flag_next = 1'b0;
              end else if (req_q.gesture == tpsc_pkg::GS_UPRIGHT) begin
                phase_next            = tpsc_pkg::PH_MEAS_EMPTY;
                phase_start_time_next = req_q.now_ms;
              end
            end
            tpsc_pkg::PH_MEAS_EMPTY: begin
              if (!req_q.meas_valid || !req_q.meas_stable) begin
                phase_next            = tpsc_pkg::PH_WAIT_EMPTY;
                empty_wait_start_next = req_q.now_ms;
              end else begin
                empty_reg_next         = req_q.meas_raw;
                phase_next             = tpsc_pkg::PH_WAIT_FULL;
                full_wait_start_next   = req_q.now_ms;
                stable_start_time_next = '0;
                last_level_next        = '0;
                is_stable_next         = 1'b0;
              end
            end
            tpsc_pkg::PH_WAIT_FULL: begin
              if (sres.t_ge) begin
                phase_next     = tpsc_pkg::PH_ERROR;
                error_reg_next = tpsc_pkg::ERR_TIMEOUT;
                mode_flag_next = 1'b0;
              end else if (req_q.gesture != tpsc_pkg::GS_UPRIGHT) begin
                is_stable_next = 1'b0;
              end else if (sres.fill_hit && sres.band_hit) begin
                if (!is_stable) begin
                  is_stable_next         = 1'b1;
                  stable_start_time_next = req_q.now_ms;
                  last_level_next        = req_q.live_level;
                end else if (sres.h_ge) begin
                  phase_next            = tpsc_pkg::PH_MEAS_FULL;
                  phase_start_time_next = req_q.now_ms;
                  is_stable_next        = 1'b0;
                end
              end else begin
                is_stable_next  = 1'b0;
                last_level_next = req_q.live_level;
              end
            end
            tpsc_pkg::PH_MEAS_FULL: begin
              if (!req_q.meas_valid || !req_q.meas_stable) begin
                phase_next           = tpsc_pkg::PH_WAIT_FULL;
                full_wait_start_next = req_q.now_ms;
                is_stable_next       = 1'b0;
              end else begin
                full_reg_next = req_q.meas_raw;
                if (!sres.fac_ok || net_grams == '0) begin
                  phase_next     = tpsc_pkg::PH_ERROR;
                  error_reg_next = tpsc_pkg::ERR_FACTOR;
                  mode_flag_next = 1'b0;
                end else begin
                  save_req = 1'b1;
                  if (!req_q.save_ok) begin
                    phase_next     = tpsc_pkg::PH_ERROR;
                    error_reg_next = tpsc_pkg::ERR_SAVE;
                    mode_flag_next = 1'b0;
                  end else begin
                    scale_reg_next        = quo;
                    success_flag_next     = 1'b1;
                    phase_next            = tpsc_pkg::PH_COMPLETE;
                    phase_start_time_next = req_q.now_ms;
                    mode_flag_next        = 1'b0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    if (clear_run) begin
      empty_reg_next         = '0;
      full_reg_next          = '0;
      stable_start_time_next = '0;
      last_level_next        = '0;
      is_stable_next         = 1'b0;
      empty_wait_start_next  = '0;
      full_wait_start_next   = '0;
    end
  end

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl <= CT_IDLE;
    end else begin
      case (ctrl)
        CT_IDLE: begin
          if (accept) ctrl <= CT_SER;
        end
        CT_SER: begin
          if (ser_done) ctrl <= need_div ? CT_DIV : CT_DONE;
        end
        CT_DIV: begin
          if (div_done) ctrl <= CT_DONE;
        end
        CT_DONE: begin
          if (commit) ctrl <= CT_IDLE;
        end
        default: ctrl <= CT_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) req_q <= req_data;
  end

  // state commit together with the response beat
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_reg         <= tpsc_pkg::PH_IDLE;
      phase_start_time  <= '0;
      empty_wait_start  <= '0;
      full_wait_start   <= '0;
      stable_start_time <= '0;
      last_level        <= '0;
      is_stable         <= 1'b0;
      empty_reg         <= '0;
      full_reg          <= '0;
      scale_reg         <= '0;
      mode_flag         <= 1'b0;
      success_flag      <= 1'b0;
      error_reg         <= tpsc_pkg::ERR_NONE;
      rsp_valid         <= 1'b0;
    end else begin
      if (commit) begin
        phase_reg         <= phase_next;
        phase_start_time  <= phase_start_time_next;
        empty_wait_start  <= empty_wait_start_next;
        full_wait_start   <= full_wait_start_next;
        stable_start_time <= stable_start_time_next;
        last_level        <= last_level_next;
        is_stable         <= is_stable_next;
        empty_reg         <= empty_reg_next;
        full_reg          <= full_reg_next;
        scale_reg         <= scale_reg_next;
        mode_flag         <= mode_flag_next;
        success_flag      <= success_flag_next;
        error_reg         <= error_reg_next;
        rsp_valid         <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp_data.phase        <= phase_next;
      rsp_data.cal_mode     <= mode_flag_next;
      rsp_data.success      <= success_flag_next;
      rsp_data.error_code   <= error_reg_next;
      rsp_data.empty_level  <= empty_reg_next;
      rsp_data.full_level   <= full_reg_next;
      rsp_data.scale_q16    <= scale_reg_next;
      rsp_data.save_request <= save_req;
    end
  end

endmodule

/* src/tpsc_checker.sv */
// ----------------------------------------------------------------------------
// tpsc_checker
// Port-level checks for the two-point scale calibration core.
// ----------------------------------------------------------------------------
module tpsc_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input tpsc_pkg::rsp_t rsp_data
);

  // one beat in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request accepted while a beat is in flight");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled response beat changed");

  a_save_phase: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.save_request |->
      rsp_data.phase == tpsc_pkg::PH_COMPLETE || rsp_data.phase == tpsc_pkg::PH_ERROR)
    else $error("save request outside complete or error");

  a_mode_off: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.phase == tpsc_pkg::PH_IDLE
      || rsp_data.phase == tpsc_pkg::PH_COMPLETE
      || rsp_data.phase == tpsc_pkg::PH_ERROR) |-> !rsp_data.cal_mode)
    else $error("calibration mode left on at end of sequence");

  a_success_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_data.success |-> rsp_data.error_code == tpsc_pkg::ERR_NONE)
    else $error("success reported with an error code");

endmodule

bind two_point_scale_calibration_fsm_core tpsc_checker u_tpsc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);

/* verif/two_point_scale_calibration_fsm_core_tb.sv */
// ----------------------------------------------------------------------------
// two_point_scale_calibration_fsm_core_tb
// Self-checking bench for the two-point calibration sequencer. A directed
// walk hits the field extremes and each exit path (abort, cancel, timeout,
// save failure at the largest factor). Randomized calibration sessions
// follow, with noise beats, under several register settings. A bit-accurate
// predictor scores every response beat field by field, and both handshakes
// see random stalls plus one long output back-pressure window.
// ----------------------------------------------------------------------------
module two_point_scale_calibration_fsm_core_tb;
  import tpsc_pkg::*;

  localparam logic [1:0] FN_SPARE  = 2'd3;
  localparam logic [1:0] GS_OTHER  = 2'd0;
  localparam logic [1:0] GS_SPARE  = 2'd3;
  localparam int         CYC_LIMIT = 400000;
  localparam int         NUM_REGS  = 7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req_data = '0;
  logic        rsp_valid;
  logic        rsp_ready = 1'b0;
  rsp_t        rsp_data;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;

  two_point_scale_calibration_fsm_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp_data  (rsp_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // pending request beats and expected response beats
  req_t        pend_q[$];
  rsp_t        exp_q[$];
  int          n_queued = 0;
  int          n_accepted = 0;
  int          n_rsp = 0;
  int          n_bad = 0;
  int          n_saved = 0;
  int          n_settings = 0;
  int          n_cyc = 0;
  logic        calm = 1'b0;
  logic        req_taken = 1'b0;
  int          gap_left = 0;
  int          stall_left = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;

  // stimulus-side view of the registers and the time cursor
  int unsigned g_cfg [NUM_REGS];
  int unsigned g_t = 0;

  // predictor state
  logic [3:0]     cal_phase;
  logic [31:0]    phase_t0, empty_t0, full_t0, steady_t0;
  logic [23:0]    last_lvl, empty_lvl, full_lvl;
  logic           steady, mode_on, saved_ok;
  logic [1:0]     err_code;
  logic [Q_W-1:0] scale_q;

  // predictor copy of the registers
  logic [15:0] pr_disp;
  logic [31:0] pr_empty_to;
  logic [31:0] pr_full_to;
  logic [11:0] pr_grams;
  logic [23:0] pr_fill;
  logic [23:0] pr_band;
  logic [15:0] pr_hold;

  function automatic longint sx(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic void clear_run();
    empty_lvl = '0;
    full_lvl  = '0;
    steady_t0 = '0;
    last_lvl  = '0;
    steady    = 1'b0;
    empty_t0  = '0;
    full_t0   = '0;
  endfunction

  function automatic void abort_run();
    mode_on   = 1'b0;
    cal_phase = PH_IDLE;
    clear_run();
  endfunction

  function automatic void fail_with(logic [1:0] code);
    cal_phase = PH_ERROR;
    err_code  = code;
    mode_on   = 1'b0;
  endfunction

  function automatic void calib_reset();
    pr_disp     = RST_STARTED_DISPLAY;
    pr_empty_to = RST_EMPTY_TIMEOUT;
    pr_full_to  = RST_FULL_TIMEOUT;
    pr_grams    = RST_NET_GRAMS;
    pr_fill     = RST_FILL_THRESHOLD;
    pr_band     = RST_STABILITY_BAND;
    pr_hold     = RST_STABLE_HOLD;
    cal_phase   = PH_IDLE;
    phase_t0    = '0;
    scale_q     = '0;
    err_code    = ERR_NONE;
    mode_on     = 1'b0;
    saved_ok    = 1'b0;
    clear_run();
  endfunction

  function automatic rsp_t calib_step(req_t r);
    rsp_t        o;
    logic        save_req;
    logic [31:0] el;
    longint      ld, diff;
    logic [63:0] quo;
    save_req = 1'b0;
    ld = sx(r.live_level);
    case (r.func)
      FN_START: begin
        mode_on   = 1'b1;
        cal_phase = PH_TRIG;
        phase_t0  = r.now_ms;
        saved_ok  = 1'b0;
        err_code  = ERR_NONE;
        clear_run();
      end
      FN_CANCEL: abort_run();
      FN_UPDATE: begin
        if (cal_phase >= PH_STARTED && cal_phase <= PH_MEAS_FULL &&
            r.gesture == GS_INVERTED) begin
          abort_run();
        end else begin
          case (cal_phase)
            PH_TRIG: begin
              cal_phase = PH_STARTED;
              phase_t0  = r.now_ms;
            end
            PH_STARTED: begin
              el = r.now_ms - phase_t0;
              if (el >= {16'd0, pr_disp}) begin
                cal_phase = PH_WAIT_EMPTY;
                empty_t0  = r.now_ms;
              end
            end
            PH_WAIT_EMPTY: begin
              el = r.now_ms - empty_t0;
              if (el >= pr_empty_to) begin
                fail_with(ERR_TIMEOUT);
              end else if (r.gesture == GS_UPRIGHT) begin
                cal_phase = PH_MEAS_EMPTY;
                phase_t0  = r.now_ms;
              end
            end
            PH_MEAS_EMPTY: begin
              if (!r.meas_valid || !r.meas_stable) begin
                cal_phase = PH_WAIT_EMPTY;
                empty_t0  = r.now_ms;
              end else begin
                empty_lvl = r.meas_raw;
                cal_phase = PH_WAIT_FULL;
                full_t0   = r.now_ms;
                steady_t0 = '0;
                last_lvl  = '0;
                steady    = 1'b0;
              end
            end
            PH_WAIT_FULL: begin
              el = r.now_ms - full_t0;
              if (el >= pr_full_to) begin
                fail_with(ERR_TIMEOUT);
              end else if (r.gesture != GS_UPRIGHT) begin
                steady = 1'b0;
              end else if (mag(ld - sx(empty_lvl)) > longint'(pr_fill) &&
                           mag(ld - sx(last_lvl)) < longint'(pr_band)) begin
                if (!steady) begin
                  steady    = 1'b1;
                  steady_t0 = r.now_ms;
                  last_lvl  = r.live_level;
                end else if (r.now_ms - steady_t0 >= {16'd0, pr_hold}) begin
                  cal_phase = PH_MEAS_FULL;
                  phase_t0  = r.now_ms;
                  steady    = 1'b0;
                end
              end else begin
                steady   = 1'b0;
                last_lvl = r.live_level;
              end
            end
            PH_MEAS_FULL: begin
              if (!r.meas_valid || !r.meas_stable) begin
                cal_phase = PH_WAIT_FULL;
                full_t0   = r.now_ms;
                steady    = 1'b0;
              end else begin
                diff     = sx(r.meas_raw) - sx(empty_lvl);
                full_lvl = r.meas_raw;
                if (diff <= 0 || pr_grams == 0 || diff > 1000 * longint'(pr_grams)) begin
                  fail_with(ERR_FACTOR);
                end else begin
                  save_req = 1'b1;
                  if (!r.save_ok) begin
                    fail_with(ERR_SAVE);
                  end else begin
                    quo       = (64'(diff) << FRAC_W) / 64'(pr_grams);
                    scale_q   = quo[Q_W-1:0];
                    saved_ok  = 1'b1;
                    cal_phase = PH_COMPLETE;
                    phase_t0  = r.now_ms;
                    mode_on   = 1'b0;
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
    o.phase        = cal_phase;
    o.cal_mode     = mode_on;
    o.success      = saved_ok;
    o.error_code   = err_code;
    o.empty_level  = empty_lvl;
    o.full_level   = full_lvl;
    o.scale_q16    = scale_q;
    o.save_request = save_req;
    return o;
  endfunction

  function automatic void cmp(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_bad++;
    end
  endfunction

  // monitor: register shadow, response scoring, request prediction
  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      calib_reset();
      exp_q.delete();
      req_taken <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          CFG_STARTED_DISPLAY: pr_disp     = cfg_wdata[15:0];
          CFG_EMPTY_TIMEOUT:   pr_empty_to = cfg_wdata;
          CFG_FULL_TIMEOUT:    pr_full_to  = cfg_wdata;
          CFG_NET_GRAMS:       pr_grams    = cfg_wdata[11:0];
          CFG_FILL_THRESHOLD:  pr_fill     = cfg_wdata[23:0];
          CFG_STABILITY_BAND:  pr_band     = cfg_wdata[23:0];
          CFG_STABLE_HOLD:     pr_hold     = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (rsp_valid && rsp_ready) begin
        n_rsp++;
        if (exp_q.size() == 0) begin
          $error("response beat with nothing expected");
          n_bad++;
        end else begin
          want = exp_q.pop_front();
          if (want.save_request && want.phase == PH_COMPLETE) n_saved++;
          cmp("phase", want.phase, rsp_data.phase);
          cmp("cal_mode", want.cal_mode, rsp_data.cal_mode);
          cmp("success", want.success, rsp_data.success);
          cmp("error_code", want.error_code, rsp_data.error_code);
          cmp("empty_level", want.empty_level, rsp_data.empty_level);
          cmp("full_level", want.full_level, rsp_data.full_level);
          cmp("scale_q16", want.scale_q16, rsp_data.scale_q16);
          cmp("save_request", want.save_request, rsp_data.save_request);
        end
      end
      if (req_valid && req_ready) begin
        exp_q.push_back(calib_step(req_data));
        n_accepted++;
      end
      req_taken <= req_valid && req_ready;
    end
  end

  // request driver
  always @(negedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || req_taken) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        req_valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        gap_left  <= $urandom_range(0, 5);
        req_valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        req_data  <= pend_q.pop_front();
        req_valid <= 1'b1;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response ready: random stalls and one long hold-off
  always @(negedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else if (!hold_done && n_rsp >= 40) begin
      hold_left <= 399;
      hold_done <= 1'b1;
      rsp_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rsp_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 5);
      rsp_ready  <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    n_cyc++;
    if (n_cyc > CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", n_cyc, exp_q.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [23:0] r24();
    return 24'($urandom);
  endfunction

  function automatic logic r1();
    return 1'($urandom);
  endfunction

  function automatic logic [1:0] idle_gest();
    return $urandom_range(0, 1) ? GS_SPARE : GS_OTHER;
  endfunction

  function automatic logic [23:0] clamp24(longint v);
    if (v > 8388607) v = 8388607;
    else if (v < -8388608) v = -8388608;
    return v[23:0];
  endfunction

  task automatic put(logic [1:0] f, logic [31:0] t, logic [1:0] g, logic [23:0] ld,
                     logic mv, logic ms, logic [23:0] raw, logic ok);
    req_t r;
    r.func         = f;
    r.now_ms       = t;
    r.gesture      = g;
    r.live_level   = ld;
    r.meas_valid   = mv;
    r.meas_stable  = ms;
    r.meas_raw     = raw;
    r.save_ok      = ok;
    pend_q.push_back(r);
    n_queued++;
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pend_q.size() != 0 || n_accepted != n_queued || exp_q.size() != 0);
  endtask

  task automatic apply_settings(input int unsigned v [NUM_REGS]);
    for (int i = 0; i < NUM_REGS; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_addr  <= 3'(i);
      cfg_wdata <= v[i];
      g_cfg[i] = v[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    n_settings++;
  endtask

  // one calibration attempt, sometimes broken off along the way
  task automatic add_session();
    longint      e, off, lvl, diff;
    int unsigned span, jit, sel;
    g_t += $urandom_range(1, 2000);
    put(FN_START, g_t, idle_gest(), r24(), r1(), r1(), r24(), r1());
    g_t += $urandom_range(0, 20);
    put(FN_UPDATE, g_t, idle_gest(), r24(), r1(), r1(), r24(), r1());
    if ($urandom_range(0, 2) == 0 && g_cfg[CFG_STARTED_DISPLAY] > 0)
      put(FN_UPDATE, g_t + $urandom_range(0, g_cfg[CFG_STARTED_DISPLAY] - 1), idle_gest(),
          r24(), r1(), r1(), r24(), r1());
    g_t += g_cfg[CFG_STARTED_DISPLAY] + $urandom_range(0, 3);
    put(FN_UPDATE, g_t, idle_gest(), r24(), r1(), r1(), r24(), r1());
    if ($urandom_range(0, 14) == 0) begin
      put(FN_UPDATE, g_t + 1, GS_INVERTED, r24(), r1(), r1(), r24(), r1());
      return;
    end
    if ($urandom_range(0, 9) == 0) begin
      g_t += g_cfg[CFG_EMPTY_TIMEOUT];
      put(FN_UPDATE, g_t, GS_UPRIGHT, r24(), r1(), r1(), r24(), r1());
      return;
    end
    repeat ($urandom_range(0, 2)) begin
      g_t += $urandom_range(1, 100);
      put(FN_UPDATE, g_t, idle_gest(), r24(), r1(), r1(), r24(), r1());
    end
    g_t += $urandom_range(1, 100);
    put(FN_UPDATE, g_t, GS_UPRIGHT, r24(), r1(), r1(), r24(), r1());
    if ($urandom_range(0, 7) == 0) begin
      sel = $urandom_range(0, 2);
      g_t++;
      put(FN_UPDATE, g_t, idle_gest(), r24(), sel == 1, sel == 2, r24(), r1());
      g_t++;
      put(FN_UPDATE, g_t, GS_UPRIGHT, r24(), r1(), r1(), r24(), r1());
    end
    e = longint'($urandom_range(0, 5000000)) - 4000000;
    g_t++;
    put(FN_UPDATE, g_t, idle_gest(), r24(), 1'b1, 1'b1, clamp24(e), r1());

    // full bottle: above the fill threshold, then steady inside the band
    off  = longint'(g_cfg[CFG_FILL_THRESHOLD]) + 1 + longint'($urandom_range(0, 200));
    lvl  = $urandom_range(0, 1) ? e + off : e - off;
    span = (g_cfg[CFG_STABILITY_BAND] > 2000) ? 2000 : g_cfg[CFG_STABILITY_BAND];
    if ($urandom_range(0, 5) == 0) begin
      g_t += $urandom_range(1, 50);
      put(FN_UPDATE, g_t, idle_gest(), r24(), r1(), r1(), r24(), r1());
    end
    g_t += $urandom_range(1, 50);
    put(FN_UPDATE, g_t, GS_UPRIGHT, clamp24(lvl), r1(), r1(), r24(), r1());
    repeat ($urandom_range(1, 3)) begin
      jit = (span == 0) ? 0 : $urandom_range(0, span - 1);
      g_t += $urandom_range(1, 50);
      put(FN_UPDATE, g_t, GS_UPRIGHT, clamp24(lvl + longint'(jit)), r1(), r1(), r24(), r1());
    end
    if ($urandom_range(0, 19) == 0) begin
      put(FN_CANCEL, g_t + 1, idle_gest(), r24(), r1(), r1(), r24(), r1());
      return;
    end
    g_t += g_cfg[CFG_STABLE_HOLD] + $urandom_range(0, 2);
    put(FN_UPDATE, g_t, GS_UPRIGHT, clamp24(lvl), r1(), r1(), r24(), r1());

    case ($urandom_range(0, 9))
      0:       diff = -longint'($urandom_range(0, 1000));
      1:       diff = 1000 * longint'(g_cfg[CFG_NET_GRAMS]) + $urandom_range(1, 1000);
      2:       diff = 1000 * longint'(g_cfg[CFG_NET_GRAMS]);
      default: diff = longint'($urandom_range(1, 1000 * g_cfg[CFG_NET_GRAMS]));
    endcase
    g_t++;
    if ($urandom_range(0, 9) == 0) begin
      sel = $urandom_range(0, 2);
      put(FN_UPDATE, g_t, idle_gest(), r24(), sel == 1, sel == 2, r24(), r1());
      return;
    end
    put(FN_UPDATE, g_t, idle_gest(), r24(), 1'b1, 1'b1, clamp24(e + diff),
        $urandom_range(0, 7) != 0);
    if ($urandom_range(0, 2) == 0)
      put(FN_UPDATE, g_t + 1, idle_gest(), r24(), r1(), r1(), r24(), r1());
  endtask

  task automatic fill_random(int n);
    int target;
    target = n_queued + n;
    while (n_queued < target) begin
      if ($urandom_range(0, 5) == 0)
        put($urandom_range(0, 3), $urandom, $urandom_range(0, 3), r24(), r1(), r1(), r24(), r1());
      else
        add_session();
    end
  endtask

  initial begin
    int unsigned s [NUM_REGS];
    logic [31:0] t0;
    g_cfg = '{RST_STARTED_DISPLAY, RST_EMPTY_TIMEOUT, RST_FULL_TIMEOUT, RST_NET_GRAMS,
              RST_FILL_THRESHOLD, RST_STABILITY_BAND, RST_STABLE_HOLD};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk under reset settings
    t0 = 32'hFFFF_FC00;
    put(FN_UPDATE, 32'hFFFF_FFFF, GS_SPARE, 24'h7F_FFFF, 1'b1, 1'b1, 24'h80_0000, 1'b1);
    put(FN_SPARE, 32'hFFFF_FFFF, GS_SPARE, 24'hFF_FFFF, 1'b1, 1'b1, 24'hFF_FFFF, 1'b1);
    put(FN_START, t0, GS_OTHER, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, t0, GS_OTHER, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, t0 + 2999, GS_UPRIGHT, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, t0 + 3000, GS_OTHER, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, t0 + 3001, GS_UPRIGHT, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, t0 + 3002, GS_OTHER, '0, 1'b1, 1'b0, '0, 1'b0);
    put(FN_UPDATE, t0 + 3003, GS_UPRIGHT, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, t0 + 3004, GS_OTHER, '0, 1'b1, 1'b1, 24'h80_0000, 1'b0);
    put(FN_UPDATE, t0 + 3005, GS_UPRIGHT, clamp24(-8388608 + 300001), 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, t0 + 3006, GS_UPRIGHT, clamp24(-8388608 + 300101), 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, t0 + 8006, GS_UPRIGHT, clamp24(-8388608 + 300101), 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, t0 + 8007, GS_OTHER, '0, 1'b1, 1'b1, clamp24(-8388608 + 830000), 1'b0);
    put(FN_START, 32'd100, GS_OTHER, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, 32'd100, GS_OTHER, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, 32'd101, GS_INVERTED, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_START, 32'd200, GS_OTHER, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_CANCEL, 32'd201, GS_OTHER, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_START, 32'd300, GS_OTHER, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, 32'd300, GS_OTHER, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, 32'd3300, GS_OTHER, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, 32'd63300, GS_UPRIGHT, '0, 1'b0, 1'b0, '0, 1'b0);
    put(FN_UPDATE, 32'd63301, GS_SPARE, '0, 1'b1, 1'b1, '0, 1'b1);
    fill_random(160);
    wait_drained();

    // low extremes of the display and hold timers and the weights, longest timeouts, widest band
    s = '{0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, 24'hFF_FFFF, 0};
    apply_settings(s);
    fill_random(120);
    wait_drained();

    // high extremes: immediate timeouts, unreachable fill level
    s = '{16'hFFFF, 0, 0, 12'hFFF, 24'hFF_FFFF, 0, 16'hFFFF};
    apply_settings(s);
    fill_random(60);
    wait_drained();

    repeat (3) begin
      s = '{$urandom_range(0, 5000), $urandom_range(0, 20000), $urandom_range(0, 40000),
            $urandom_range(1, 4095), $urandom_range(0, 2000000), $urandom_range(0, 20000),
            $urandom_range(0, 8000)};
      apply_settings(s);
      fill_random(110);
      wait_drained();
    end

    // closing stretch at full rate
    calm = 1'b1;
    s = '{1000, 30000, 60000, 1000, 100000, 3000, 2000};
    apply_settings(s);
    fill_random(160);
    wait_drained();
    repeat (150) @(posedge clk);

    $display("%0d request beats under %0d register settings, %0d response beats checked",
             n_accepted, n_settings + 1, n_rsp);
    $display("%0d calibrations saved, long output hold-off applied: %0d", n_saved, hold_done);
    if (n_bad == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* two_point_scale_calibration_fsm_core.f */
src/tpsc_pkg.sv
src/tpsc_serial.sv
src/tpsc_div.sv
src/two_point_scale_calibration_fsm_core.sv
src/tpsc_checker.sv
verif/two_point_scale_calibration_fsm_core_tb.sv
